### rtl/gather_address_with_index_wrap_macros.svh
// ----------------------------------------------------------------------------
// Gather address generator assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GATHER_ADDRESS_WITH_INDEX_WRAP_MACROS_SVH
`define GATHER_ADDRESS_WITH_INDEX_WRAP_MACROS_SVH

`ifndef SYNTHESIS

// Property checked while out of reset
`define GAW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define GAW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GAW_ASSERT(lbl, clk, rst_n, prop, msg)
`define GAW_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/gaw_pkg.sv
// ----------------------------------------------------------------------------
// Gather address generator package
// Request types, register map and remainder step shared by the RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gaw_pkg;

    localparam int IDX_W       = 64;
    localparam int POS_W       = 31;
    localparam int FIELD_OFF_W = 32;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = IDX_W / DIV_BITS;
    localparam int DEF_OFFSET_WIDTH = 32;
    localparam int MAC_STAGES  = 4;
    localparam int ADDR_W      = 4;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_OUTER = 2'd0;
    localparam logic [1:0] REG_AXIS  = 2'd1;
    localparam logic [1:0] REG_INNER = 2'd2;
    localparam logic [1:0] REG_INDEX = 2'd3;

    typedef struct packed {
        logic signed [IDX_W-1:0] index_value;
        logic [POS_W-1:0]        outer_pos;
        logic [POS_W-1:0]        index_pos;
        logic [POS_W-1:0]        inner_pos;
    } t_in_req;

    typedef struct packed {
        logic [FIELD_OFF_W-1:0] source_offset;
        logic [FIELD_OFF_W-1:0] dest_offset;
        logic [POS_W-1:0]       wrapped_index;
        logic                   error;
    } t_out_req;

    // Positions riding alongside the remainder pipeline
    typedef struct packed {
        logic [POS_W-1:0] outer_pos;
        logic [POS_W-1:0] index_pos;
        logic [POS_W-1:0] inner_pos;
        logic             neg;
    } t_side;

    // Result of the wrap unit handed to the offset stages
    typedef struct packed {
        logic             vld;
        logic             err;
        logic [POS_W-1:0] wrapped;
        logic [POS_W-1:0] outer_pos;
        logic [POS_W-1:0] index_pos;
        logic [POS_W-1:0] inner_pos;
    } t_wrap_res;

    // One restoring remainder step: shift in a bit, subtract if it fits
    function automatic logic [POS_W-1:0] div_step(
        input logic [POS_W-1:0] rem,
        input logic             b,
        input logic [POS_W-1:0] len
    );
        logic [POS_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, len}) begin
            t = t - {1'b0, len};
        end
        return t[POS_W-1:0];
    endfunction

endpackage

### rtl/gaw_wrap.sv
// ----------------------------------------------------------------------------
// Gather address generator: index wrap pipeline
// Euclidean modulo of a signed 64-bit index by the axis length, two
// remainder bits per stage, one request per cycle while i_en is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaw_wrap (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  gaw_pkg::t_in_req          i_req,
    input  logic [gaw_pkg::POS_W-1:0] i_axis_cnt,
    output gaw_pkg::t_wrap_res        o_res
);
    import gaw_pkg::*;

    logic [IDX_W-1:0] r_mag  [0:DIV_STAGES];
    logic [POS_W-1:0] r_rem  [0:DIV_STAGES];
    t_side            r_side [0:DIV_STAGES];
    logic             r_vld  [0:DIV_STAGES];
    t_wrap_res        r_res;

    logic [IDX_W-1:0] n_mag0;
    t_side            n_side0;

    // Entry: magnitude of the index and its sign
    always_comb begin
        n_mag0 = i_req.index_value[IDX_W-1] ? (~i_req.index_value + 1'b1)
                                            : i_req.index_value;
        n_side0.outer_pos = i_req.outer_pos;
        n_side0.index_pos = i_req.index_pos;
        n_side0.inner_pos = i_req.inner_pos;
        n_side0.neg       = i_req.index_value[IDX_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0]  <= n_mag0;
            r_rem[0]  <= '0;
            r_side[0] <= n_side0;
        end
    end

    // Remainder stages, MSB first
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        logic [POS_W-1:0] n_rem_a;
        logic [POS_W-1:0] n_rem_b;

        always_comb begin
            n_rem_a = div_step(r_rem[k-1], r_mag[k-1][IDX_W-1], i_axis_cnt);
            n_rem_b = div_step(n_rem_a, r_mag[k-1][IDX_W-2], i_axis_cnt);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem_b;
                r_mag[k]  <= r_mag[k-1] << DIV_BITS;
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Final fix-up: negative indexes fold back from the top of the axis; a zero axis length flags an error
    t_wrap_res n_res;
    always_comb begin
        n_res.vld       = r_vld[DIV_STAGES];
        n_res.err       = (i_axis_cnt == '0);
        n_res.outer_pos = r_side[DIV_STAGES].outer_pos;
        n_res.index_pos = r_side[DIV_STAGES].index_pos;
        n_res.inner_pos = r_side[DIV_STAGES].inner_pos;
        if (n_res.err) begin
            n_res.wrapped = '0;
        end else if (r_side[DIV_STAGES].neg && (r_rem[DIV_STAGES] != '0)) begin
            n_res.wrapped = i_axis_cnt - r_rem[DIV_STAGES];
        end else begin
            n_res.wrapped = r_rem[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else if (i_en) begin
            r_res.vld <= n_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.err       <= n_res.err;
            r_res.wrapped   <= n_res.wrapped;
            r_res.outer_pos <= n_res.outer_pos;
            r_res.index_pos <= n_res.index_pos;
            r_res.inner_pos <= n_res.inner_pos;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/gaw_mac.sv
// ----------------------------------------------------------------------------
// Gather address generator: offset multiply-accumulate
// ((x*y + z)*k + c) mod 2^OFFSET_WIDTH over four register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaw_mac #(
    parameter int OFFSET_WIDTH = gaw_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [gaw_pkg::POS_W-1:0] i_x,
    input  logic [gaw_pkg::POS_W-1:0] i_y,
    input  logic [gaw_pkg::POS_W-1:0] i_z,
    input  logic [gaw_pkg::POS_W-1:0] i_k,
    input  logic [gaw_pkg::POS_W-1:0] i_c,
    output logic [OFFSET_WIDTH-1:0]   o_sum
);
    import gaw_pkg::*;

    localparam int LO_W = (OFFSET_WIDTH + 1) / 2;
    localparam int HI_W = OFFSET_WIDTH - LO_W;

    logic [OFFSET_WIDTH-1:0] r_xy;
    logic [OFFSET_WIDTH-1:0] r_a;
    logic [OFFSET_WIDTH-1:0] r_plo;
    logic [HI_W-1:0]         r_phi;
    logic [OFFSET_WIDTH-1:0] r_sum;
    logic [POS_W-1:0]        r_z;
    logic [POS_W-1:0]        r_c1;
    logic [POS_W-1:0]        r_c2;
    logic [POS_W-1:0]        r_c3;

    logic [2*POS_W-1:0]  n_xy;
    logic [LO_W+POS_W-1:0] n_plo;
    logic [HI_W+POS_W-1:0] n_phi;

    // Partial products: the scaled base is split in two halves
    always_comb begin
        n_xy  = i_x * i_y;
        n_plo = r_a[LO_W-1:0] * i_k;
        n_phi = r_a[OFFSET_WIDTH-1:LO_W] * i_k;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xy  <= n_xy[OFFSET_WIDTH-1:0];
            r_z   <= i_z;
            r_c1  <= i_c;
            r_a   <= r_xy + OFFSET_WIDTH'(r_z);
            r_c2  <= r_c1;
            r_plo <= n_plo[OFFSET_WIDTH-1:0];
            r_phi <= n_phi[HI_W-1:0];
            r_c3  <= r_c2;
            r_sum <= r_plo + {r_phi, {LO_W{1'b0}}} + OFFSET_WIDTH'(r_c3);
        end
    end

    assign o_sum = r_sum;

endmodule

### rtl/gather_address_with_index_wrap.sv
// ----------------------------------------------------------------------------
// Gather address generator with index wrap
// Wraps a signed index into the axis length and returns the source and
// destination element offsets of a gather along one array axis.
// ----------------------------------------------------------------------------
//   channel   direction  handshake           payload
//   in        input      i_in_valid/o_in_stall   i_in_req  (t_in_req)
//   out       output     o_out_valid/i_out_stall o_out_req (t_out_req)
//   config    input      APB psel/penable        paddr/pwdata/prdata
//
// One request enters per cycle unless the output stalls; the pipeline has 1 entry stage,
// 32 remainder stages of two bits each, 1 fold stage and 4 multiply stages.
// Full throughput; up to 38 requests are in flight at once.
// A stall on a valid output freezes the whole pipeline; o_in_stall follows it.
// Synchronous reset clears valid bits; the configuration registers reset to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gather_address_with_index_wrap_macros.svh"

module gather_address_with_index_wrap #(
    parameter int OFFSET_WIDTH = gaw_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  gaw_pkg::t_in_req           i_in_req,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output gaw_pkg::t_out_req          o_out_req,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gaw_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import gaw_pkg::*;

    logic [POS_W-1:0] r_outer_cnt;
    logic [POS_W-1:0] r_axis_cnt;
    logic [POS_W-1:0] r_inner_cnt;
    logic [POS_W-1:0] r_index_cnt;

    logic             r_mvld [0:MAC_STAGES-1];
    logic             r_merr [0:MAC_STAGES-1];
    logic [POS_W-1:0] r_mw   [0:MAC_STAGES-1];

    logic                    en;
    t_wrap_res               wres;
    logic [OFFSET_WIDTH-1:0] src_sum;
    logic [OFFSET_WIDTH-1:0] dst_sum;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_cnt <= POS_W'(1);
            r_axis_cnt  <= POS_W'(1);
            r_inner_cnt <= POS_W'(1);
            r_index_cnt <= POS_W'(1);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_OUTER: r_outer_cnt <= pwdata[POS_W-1:0];
                REG_AXIS:  r_axis_cnt  <= pwdata[POS_W-1:0];
                REG_INNER: r_inner_cnt <= pwdata[POS_W-1:0];
                REG_INDEX: r_index_cnt <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OUTER: prdata = {1'b0, r_outer_cnt};
            REG_AXIS:  prdata = {1'b0, r_axis_cnt};
            REG_INNER: prdata = {1'b0, r_inner_cnt};
            REG_INDEX: prdata = {1'b0, r_index_cnt};
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Global advance: hold everything while the output request waits
    assign en         = !(r_mvld[MAC_STAGES-1] && i_out_stall);
    assign o_in_stall = !en;

    gaw_wrap u_wrap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_req      (i_in_req),
        .i_axis_cnt (r_axis_cnt),
        .o_res      (wres)
    );

    // Source: (outer*axis_cnt + wrapped)*inner + inner_pos
    gaw_mac #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_src_mac (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (wres.outer_pos),
        .i_y   (r_axis_cnt),
        .i_z   (wres.wrapped),
        .i_k   (r_inner_cnt),
        .i_c   (wres.inner_pos),
        .o_sum (src_sum)
    );

    // Destination: (outer*index_count + index_pos)*inner + inner_pos
    gaw_mac #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_dst_mac (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (wres.outer_pos),
        .i_y   (r_index_cnt),
        .i_z   (wres.index_pos),
        .i_k   (r_inner_cnt),
        .i_c   (wres.inner_pos),
        .o_sum (dst_sum)
    );

    // Valid, error and wrapped index alongside the multiply stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAC_STAGES; s++) begin
                r_mvld[s] <= 1'b0;
            end
        end else if (en) begin
            r_mvld[0] <= wres.vld;
            for (int s = 1; s < MAC_STAGES; s++) begin
                r_mvld[s] <= r_mvld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_merr[0] <= wres.err;
            r_mw[0]   <= wres.wrapped;
            for (int s = 1; s < MAC_STAGES; s++) begin
                r_merr[s] <= r_merr[s-1];
                r_mw[s]   <= r_mw[s-1];
            end
        end
    end

    // Output request; a zero axis length forces zero offsets
    always_comb begin
        o_out_valid             = r_mvld[MAC_STAGES-1];
        o_out_req.error         = r_merr[MAC_STAGES-1];
        o_out_req.wrapped_index = r_mw[MAC_STAGES-1];
        o_out_req.source_offset = r_merr[MAC_STAGES-1] ? '0 : FIELD_OFF_W'(src_sum);
        o_out_req.dest_offset   = r_merr[MAC_STAGES-1] ? '0 : FIELD_OFF_W'(dst_sum);
    end

    `GAW_ASSERT(a_wrap_in_range, i_clk, i_rst_n, o_out_valid && !o_out_req.error |-> o_out_req.wrapped_index < r_axis_cnt, "wrapped index not below axis length")
    `GAW_ASSERT(a_err_matches_len, i_clk, i_rst_n, o_out_valid |-> (o_out_req.error == (r_axis_cnt == '0)), "error flag disagrees with axis length")
    `GAW_ASSERT(a_stall_freezes, i_clk, i_rst_n, o_in_stall |=> $stable(r_mvld[MAC_STAGES-2]), "pipeline moved during stall")

endmodule

### tb/gaw_checker.sv
// ----------------------------------------------------------------------------
// Gather address checker
// Watches the request and result channels, predicts source and destination
// offsets from the shadow registers, and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaw_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  gaw_pkg::t_in_req  i_in_req,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  gaw_pkg::t_out_req i_out_req,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output logic              o_accept
);
    import gaw_pkg::*;

    logic [30:0] outer_cnt, axis_cnt, inner_cnt, index_cnt;
    t_out_req    addr_queue[$];

    // Euclidean modulo of a signed 64-bit index by a nonzero length
    function automatic logic [30:0] wrap_idx(logic signed [63:0] raw, logic [30:0] len);
        logic [63:0] mag;
        logic [63:0] r;
        if (raw[63]) begin
            mag = 64'd0 - raw;
            r = mag % {33'd0, len};
            return (r == 0) ? 31'd0 : len - r[30:0];
        end
        r = raw % {33'd0, len};
        return r[30:0];
    endfunction

    function automatic t_out_req predict_addr(t_in_req q);
        t_out_req    o;
        logic [63:0] w, src, dst;
        o = '0;
        if (axis_cnt == 0) begin
            o.error = 1'b1;
            return o;
        end
        w   = {33'd0, wrap_idx(q.index_value, axis_cnt)};
        src = ({33'd0, q.outer_pos} * {33'd0, axis_cnt} + w) * {33'd0, inner_cnt}
              + {33'd0, q.inner_pos};
        dst = ({33'd0, q.outer_pos} * {33'd0, index_cnt} + {33'd0, q.index_pos})
              * {33'd0, inner_cnt} + {33'd0, q.inner_pos};
        o.source_offset = src[31:0];
        o.dest_offset   = dst[31:0];
        o.wrapped_index = w[30:0];
        return o;
    endfunction

    assign o_pending = addr_queue.size();
    assign o_accept  = (i_in_valid && !i_in_stall) || (i_out_valid && !i_out_stall);

    always @(posedge i_clk) begin
        t_out_req exp_r;
        if (!i_rst_n) begin
            outer_cnt <= 31'd1;
            axis_cnt  <= 31'd1;
            inner_cnt <= 31'd1;
            index_cnt <= 31'd1;
            o_errors  <= 0;
            addr_queue.delete();
        end else begin
            // shadow register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OUTER: outer_cnt <= i_cfg_data[30:0];
                    REG_AXIS:  axis_cnt  <= i_cfg_data[30:0];
                    REG_INNER: inner_cnt <= i_cfg_data[30:0];
                    REG_INDEX: index_cnt <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) addr_queue.push_back(predict_addr(i_in_req));
            // compare result against oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (addr_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_req);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = addr_queue.pop_front();
                    if (exp_r.source_offset !== i_out_req.source_offset ||
                        exp_r.dest_offset !== i_out_req.dest_offset ||
                        exp_r.wrapped_index !== i_out_req.wrapped_index ||
                        exp_r.error !== i_out_req.error) begin
                        $display("%0t: mismatch expected src=%h dst=%h w=%h e=%b",
                                 $time, exp_r.source_offset, exp_r.dest_offset,
                                 exp_r.wrapped_index, exp_r.error);
                        $display("%0t:          actual   src=%h dst=%h w=%h e=%b",
                                 $time, i_out_req.source_offset, i_out_req.dest_offset,
                                 i_out_req.wrapped_index, i_out_req.error);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/tb_gather_address_with_index_wrap.sv
// ----------------------------------------------------------------------------
// Gather address generator testbench
// Drives directed and random index requests over several register settings
// with random idling on both channels; a checker module judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gather_address_with_index_wrap;
    import gaw_pkg::*;

    localparam int LATENCY = 38;
    localparam int WDOG    = 20000;

    logic        i_clk, i_rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    t_in_req     in_req;
    t_out_req    out_req;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          errors, pending, idle_cycles;
    logic        accept;
    int          send_idle, recv_idle;

    gather_address_with_index_wrap dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_req(in_req),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_req(out_req),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gaw_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_req(in_req),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_req(out_req),
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_idx(paddr[3:2]), .i_cfg_data(pwdata),
        .o_errors(errors), .o_pending(pending), .o_accept(accept)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall at random
    always @(negedge i_clk) out_stall <= ($urandom_range(99) < recv_idle);

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || accept || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // drop valid, drain all results, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic set_shape(logic [30:0] o, logic [30:0] a, logic [30:0] n, logic [30:0] c);
        write_reg(REG_OUTER, {1'b0, o});
        write_reg(REG_AXIS,  {1'b0, a});
        write_reg(REG_INNER, {1'b0, n});
        write_reg(REG_INDEX, {1'b0, c});
    endtask

    // present one request, honoring sender idling, until accepted;
    // valid stays up so the next request can follow back to back
    task automatic send_req(t_in_req q);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= q;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [30:0] rand_pos(logic [30:0] lim);
        case ($urandom_range(3))
            0:       return 31'($urandom);
            1:       return 31'h7FFF_FFFF;
            default: return (lim == 0) ? 31'd0 : 31'($urandom_range(lim - 1));
        endcase
    endfunction

    task automatic rand_req(logic [30:0] a, logic [30:0] o, logic [30:0] n, logic [30:0] c);
        t_in_req q;
        case ($urandom_range(4))
            0: q.index_value = {$urandom, $urandom};
            1: q.index_value = 64'($signed($urandom_range(2 * a + 4))) - 64'(a) - 2;
            2: q.index_value = $urandom_range(1) ? 64'h8000_0000_0000_0000
                                                 : 64'h7FFF_FFFF_FFFF_FFFF;
            default: q.index_value = $signed(64'($urandom_range(1000))) - 500;
        endcase
        q.outer_pos = rand_pos(o);
        q.index_pos = rand_pos(c);
        q.inner_pos = rand_pos(n);
        send_req(q);
    endtask

    initial begin
        t_in_req     q;
        logic [30:0] o, a, n, c;
        in_valid = 1'b0; in_req = '0; out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        send_idle = 0; recv_idle = 0; idle_cycles = 0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: small shape, extremes, zero axis, negative wrap
        set_shape(31'd3, 31'd7, 31'd5, 31'd4);
        q = '0;
        q.index_value = -64'sd1;                       send_req(q);
        q.index_value = -64'sd7;                       send_req(q);
        q.index_value = -64'sd8;                       send_req(q);
        q.index_value = 64'sd13;                       send_req(q);
        q.index_value = 64'h8000_0000_0000_0000;       send_req(q);
        q.index_value = 64'h7FFF_FFFF_FFFF_FFFF;       send_req(q);
        q = '1;                                        send_req(q);
        q.index_value = 64'sd2; q.outer_pos = 31'd2; q.index_pos = 31'd3;
        q.inner_pos = 31'd4;                           send_req(q);
        drain();
        set_shape(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        q = '1;                                        send_req(q);
        q.index_value = 64'h8000_0000_0000_0000;       send_req(q);
        q = '0; q.index_value = -64'sd2;               send_req(q);
        drain();
        set_shape(31'd2, 31'd0, 31'd3, 31'd2);
        q = '1;                                        send_req(q);
        q = '0; q.index_value = 64'sd5;                send_req(q);
        drain();
        set_shape(31'd0, 31'd1, 31'd0, 31'd0);
        q = '1;                                        send_req(q);
        q.index_value = -64'sd3;                       send_req(q);
        drain();

        // random phases over varied shapes and idling mixes
        for (int ph = 0; ph < 12; ph++) begin
            send_idle = (ph < 4) ? 11 : (ph < 8) ? 48 : 0;
            recv_idle = (ph < 4) ? 48 : (ph < 8) ? 11 : 0;
            o = (ph % 4 == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 50));
            a = (ph == 5) ? 31'd0 : (ph % 4 == 1) ? 31'h7FFF_FFFF
                : (ph % 4 == 2) ? 31'd1 : 31'($urandom_range(1, 1000));
            n = (ph % 3 == 0) ? 31'd1 : 31'($urandom);
            c = (ph % 3 == 1) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 64));
            set_shape(o, a, n, c);
            for (int k = 0; k < 140; k++) begin
                rand_req(a, o, n, c);
                // sender holds off until everything is back
                if (k == 70 && ph == 2) begin
                    in_valid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        drain();
        if (errors == 0) $display("Simulation PASSED");
        else             $display("Simulation FAILED");
        $finish;
    end
endmodule
